FILE: hw/rtl/hufd_pkg.sv
package hufd_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int NODE_LIMIT    = 2 * ALPHABET_SIZE - 1;
	localparam int TABLE_DEPTH   = ALPHABET_SIZE - 1;
	localparam int STACK_DEPTH   = 256;

	localparam int NODE_W  = 9;
	localparam int FREE_W  = 10;
	localparam int DEPTH_W = 9;
	localparam int TIDX_W  = 8;
	localparam int SIDX_W  = 8;
	localparam int COUNT_W = 24;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_TREE_SIZE = 2'd1,
		ERR_EARLY_END = 2'd2,
		ERR_ONE_LEAF  = 2'd3
	} hufd_err_t;

	typedef enum logic [1:0] {
		PH_TREE,
		PH_DECODE,
		PH_DONE
	} hufd_phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_BITS,
		SQ_FINISH
	} hufd_seq_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} hufd_in_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_result;
		logic [1:0] error_code;
	} hufd_out_t;

	// stack entry: bit 9 = right child pending, bits 8..0 = node
	typedef struct packed {
		logic              right;
		logic [NODE_W-1:0] node;
	} hufd_stk_t;

	typedef struct packed {
		logic              l_we;
		logic              r_we;
		logic [TIDX_W-1:0] t_addr;
		logic [NODE_W-1:0] t_data;
		logic              s_we;
		logic [SIDX_W-1:0] s_addr;
		hufd_stk_t         s_data;
	} hufd_wr_t;

	// internal nodes 256..510 map to rows 0..254, anything else to row 0
	function automatic logic [TIDX_W-1:0] tbl_idx(input logic [NODE_W-1:0] node);
		tbl_idx = (node[NODE_W-1] && node[TIDX_W-1:0] != TIDX_W'(TABLE_DEPTH)) ?
			node[TIDX_W-1:0] : '0;
	endfunction

endpackage

FILE: hw/rtl/huffman_decoder_embedded_tree.sv
// Huffman decoder for frames that carry their own pre-order code tree.
// Input channel (in_valid/in_ready, in_data): one compressed byte per item,
// bits used msb first; last_byte closes the frame. Output channel
// (out_valid/out_ready, out_data): one decoded symbol per item, last_result
// on the final symbol or on an error item, error_code says which error.
// cfg_we/cfg_wdata write out_length, the symbol count of a frame.
// A single bit-step unit handles one bit per cycle while neither a full output
// nor a fresh table write holds it: a byte is taken, its eight bits are then
// stepped in turn, and a byte marked last adds a closing step to end the frame.
// The child memories have registered read data, so the first code bit that
// follows the leaf completing the tree in the same byte waits for that write.
// The output register holds one item; while it is full and not taken, the
// bit unit stops, so a stalled receiver holds the block without loss.
// in_ready is high only between bytes. A symbol appears on out_data the
// cycle after the step of its last code bit.
// Reset clears control state and out_length and starts a new frame; the
// tree tables and the parse stack are not cleared and need no sweep.
module huffman_decoder_embedded_tree (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hufd_pkg::hufd_in_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hufd_pkg::hufd_out_t        out_data,
	input  logic                       cfg_we,
	input  logic [hufd_pkg::COUNT_W-1:0] cfg_wdata
);
	import hufd_pkg::*;

	hufd_seq_t           seq_q, seq_d;
	logic [2:0]          bit_cnt_q, bit_cnt_d;
	logic [7:0]          byte_q, byte_d;
	logic                last_q, last_d;
	hufd_phase_t         phase_q, phase_d;
	logic [3:0]          leaf_bits_q, leaf_bits_d;
	logic [7:0]          leaf_shift_q, leaf_shift_d;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	hufd_stk_t           top_q, top_d;
	logic [FREE_W-1:0]   next_free_q, next_free_d;
	logic [NODE_W-1:0]   root_q, root_d;
	logic [NODE_W-1:0]   walk_q, walk_d;
	logic [COUNT_W-1:0]  done_cnt_q, done_cnt_d;
	logic [COUNT_W-1:0]  out_len_q;
	logic                wrote_q;
	logic                out_valid_q, out_valid_d;
	hufd_out_t           out_q, out_d;

	hufd_wr_t            wr;
	logic [NODE_W-1:0]   l_rdata, r_rdata;
	hufd_stk_t           s_rdata;

	logic                bit_v;
	logic                out_free;
	logic                need_fresh;
	logic                go;
	logic [7:0]          sh;
	logic [3:0]          lb;
	logic [NODE_W-1:0]   child;
	logic [NODE_W-1:0]   new_node;
	logic [COUNT_W-1:0]  cnt_inc;
	logic [DEPTH_W-1:0]  depth_dec;

	hufd_tables u_tables (
		.clk     (clk),
		.wr      (wr),
		.t_raddr (tbl_idx(walk_d)),
		.s_raddr (SIDX_W'(depth_d - DEPTH_W'(2))),
		.l_rdata (l_rdata),
		.r_rdata (r_rdata),
		.s_rdata (s_rdata)
	);

	assign in_ready  = (seq_q == SQ_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign bit_v      = byte_q[7];
	assign out_free   = !out_valid_q || out_ready;
	// decode steps read the child tables, a closing leaf may pop the stack
	assign need_fresh = (phase_q == PH_DECODE) ||
		(phase_q == PH_TREE && leaf_bits_q == 4'd1);
	assign go         = (seq_q == SQ_BITS) && out_free && !(need_fresh && wrote_q);

	assign sh        = {leaf_shift_q[6:0], bit_v};
	assign lb        = leaf_bits_q - 4'd1;
	assign child     = bit_v ? r_rdata : l_rdata;
	assign new_node  = next_free_q[NODE_W-1:0];
	assign cnt_inc   = done_cnt_q + COUNT_W'(1);
	assign depth_dec = depth_q - DEPTH_W'(1);

	always_comb begin
		seq_d        = seq_q;
		bit_cnt_d    = bit_cnt_q;
		byte_d       = byte_q;
		last_d       = last_q;
		phase_d      = phase_q;
		leaf_bits_d  = leaf_bits_q;
		leaf_shift_d = leaf_shift_q;
		depth_d      = depth_q;
		top_d        = top_q;
		next_free_d  = next_free_q;
		root_d       = root_q;
		walk_d       = walk_q;
		done_cnt_d   = done_cnt_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_d        = out_q;
		wr           = '0;
		wr.t_addr    = tbl_idx(top_q.node);
		wr.s_addr    = SIDX_W'(depth_dec);
		wr.s_data    = '{right: 1'b1, node: top_q.node};

		unique case (seq_q)
			SQ_IDLE: begin
				if (in_valid) begin
					byte_d    = in_data.in_byte;
					last_d    = in_data.last_byte;
					bit_cnt_d = '0;
					seq_d     = SQ_BITS;
				end
			end
			SQ_BITS: begin
				if (go) begin
					unique case (phase_q)
						PH_TREE: begin
							if (leaf_bits_q != 4'd0) begin
								leaf_shift_d = sh;
								leaf_bits_d  = lb;
								if (lb == 4'd0) begin
									wr.t_data = {1'b0, sh};
									if (depth_q == '0) begin
										root_d      = {1'b0, sh};
										out_d       = '{symbol: 8'd0, last_result: 1'b1,
											error_code: ERR_ONE_LEAF};
										out_valid_d = 1'b1;
										phase_d     = PH_DONE;
									end else if (!top_q.right) begin
										wr.l_we     = 1'b1;
										top_d.right = 1'b1;
									end else begin
										wr.r_we = 1'b1;
										depth_d = depth_dec;
										if (depth_dec == '0) begin
											walk_d     = root_q;
											done_cnt_d = '0;
											phase_d    = (out_len_q == '0) ? PH_DONE : PH_DECODE;
										end else begin
											top_d = s_rdata;
										end
									end
								end
							end else if (bit_v) begin
								if (next_free_q >= FREE_W'(NODE_LIMIT)) begin
									out_d       = '{symbol: 8'd0, last_result: 1'b1,
										error_code: ERR_TREE_SIZE};
									out_valid_d = 1'b1;
									phase_d     = PH_DONE;
								end else begin
									next_free_d = next_free_q + FREE_W'(1);
									wr.t_data   = new_node;
									if (depth_q == '0) begin
										root_d  = new_node;
										top_d   = '{right: 1'b0, node: new_node};
										depth_d = DEPTH_W'(1);
									end else if (!top_q.right) begin
										wr.l_we = 1'b1;
										if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
											// the parent moves into the stack memory
											wr.s_we = 1'b1;
											top_d   = '{right: 1'b0, node: new_node};
											depth_d = depth_q + DEPTH_W'(1);
										end else begin
											top_d.right = 1'b1;
										end
									end else begin
										// parent done: new node takes its slot
										wr.r_we = 1'b1;
										top_d   = '{right: 1'b0, node: new_node};
									end
								end
							end else begin
								leaf_bits_d  = 4'd8;
								leaf_shift_d = '0;
							end
						end
						PH_DECODE: begin
							if (!child[NODE_W-1]) begin
								done_cnt_d  = cnt_inc;
								out_d       = '{symbol: child[7:0],
									last_result: (cnt_inc >= out_len_q), error_code: ERR_NONE};
								out_valid_d = 1'b1;
								walk_d      = root_q;
								if (cnt_inc >= out_len_q) begin
									phase_d = PH_DONE;
								end
							end else begin
								walk_d = child;
							end
						end
						PH_DONE: begin
						end
						default: begin
						end
					endcase
					byte_d    = {byte_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						seq_d = last_q ? SQ_FINISH : SQ_IDLE;
					end
				end
			end
			SQ_FINISH: begin
				if (phase_q != PH_DONE) begin
					if (out_free) begin
						out_d       = '{symbol: 8'd0, last_result: 1'b1,
							error_code: ERR_EARLY_END};
						out_valid_d = 1'b1;
					end
				end
				if (phase_q == PH_DONE || out_free) begin
					seq_d        = SQ_IDLE;
					phase_d      = PH_TREE;
					leaf_bits_d  = '0;
					leaf_shift_d = '0;
					depth_d      = '0;
					next_free_d  = FREE_W'(ALPHABET_SIZE);
					root_d       = '0;
					walk_d       = '0;
					done_cnt_d   = '0;
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SQ_IDLE;
			bit_cnt_q    <= '0;
			last_q       <= 1'b0;
			phase_q      <= PH_TREE;
			leaf_bits_q  <= '0;
			leaf_shift_q <= '0;
			depth_q      <= '0;
			top_q        <= '0;
			next_free_q  <= FREE_W'(ALPHABET_SIZE);
			root_q       <= '0;
			walk_q       <= '0;
			done_cnt_q   <= '0;
			out_len_q    <= '0;
			wrote_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			seq_q        <= seq_d;
			bit_cnt_q    <= bit_cnt_d;
			last_q       <= last_d;
			phase_q      <= phase_d;
			leaf_bits_q  <= leaf_bits_d;
			leaf_shift_q <= leaf_shift_d;
			depth_q      <= depth_d;
			top_q        <= top_d;
			next_free_q  <= next_free_d;
			root_q       <= root_d;
			walk_q       <= walk_d;
			done_cnt_q   <= done_cnt_d;
			wrote_q      <= wr.l_we || wr.r_we || wr.s_we;
			out_valid_q  <= out_valid_d;
			if (cfg_we) begin
				out_len_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		out_q  <= out_d;
	end

endmodule

FILE: hw/rtl/hufd_tables.sv
module hufd_tables (
	input  logic                      clk,
	input  hufd_pkg::hufd_wr_t        wr,
	input  logic [hufd_pkg::TIDX_W-1:0] t_raddr,
	input  logic [hufd_pkg::SIDX_W-1:0] s_raddr,
	output logic [hufd_pkg::NODE_W-1:0] l_rdata,
	output logic [hufd_pkg::NODE_W-1:0] r_rdata,
	output hufd_pkg::hufd_stk_t       s_rdata
);
	import hufd_pkg::*;

	logic [NODE_W-1:0] left_mem  [0:TABLE_DEPTH-1];
	logic [NODE_W-1:0] right_mem [0:TABLE_DEPTH-1];
	hufd_stk_t         stack_mem [0:STACK_DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr.l_we) begin
			left_mem[wr.t_addr] <= wr.t_data;
		end
		l_rdata <= left_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.r_we) begin
			right_mem[wr.t_addr] <= wr.t_data;
		end
		r_rdata <= right_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.s_we) begin
			stack_mem[wr.s_addr] <= wr.s_data;
		end
		s_rdata <= stack_mem[s_raddr];
	end

endmodule

FILE: verif/hufd_checker.sv
`timescale 1ns / 1ps

module hufd_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  hufd_pkg::hufd_in_t           in_data,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  hufd_pkg::hufd_out_t          out_data,
	input  logic                         cfg_we,
	input  logic [hufd_pkg::COUNT_W-1:0] cfg_wdata,
	output int                           fails,
	output int                           pending
);
	import hufd_pkg::*;

	// own copy of the decoder state
	logic [NODE_W-1:0]  lchild [TABLE_DEPTH];
	logic [NODE_W-1:0]  rchild [TABLE_DEPTH];
	hufd_stk_t          stk [STACK_DEPTH];
	logic [DEPTH_W-1:0] depth;
	logic [FREE_W-1:0]  free_node;
	logic [NODE_W-1:0]  root;
	logic [NODE_W-1:0]  walk;
	hufd_phase_t        phase;
	logic [7:0]         shreg;
	logic [3:0]         bits_left;
	logic [COUNT_W-1:0] done_cnt;
	logic [COUNT_W-1:0] frame_len;

	hufd_out_t due_symbols[$];
	hufd_out_t want;

	initial fails = 0;
	initial pending = 0;

	function automatic void new_frame();
		depth     = '0;
		free_node = FREE_W'(ALPHABET_SIZE);
		root      = '0;
		walk      = '0;
		phase     = PH_TREE;
		shreg     = '0;
		bits_left = '0;
		done_cnt  = '0;
	endfunction

	function automatic void add_due(logic [7:0] sym, logic lst, hufd_err_t code);
		due_symbols.push_back('{symbol: sym, last_result: lst, error_code: code});
	endfunction

	// internal node number to table row, out of range rows fold to zero
	function automatic logic [7:0] row_of(logic [NODE_W-1:0] node);
		logic [NODE_W-1:0] r;
		r = node - NODE_W'(ALPHABET_SIZE);
		return (r < NODE_W'(TABLE_DEPTH)) ? r[7:0] : 8'd0;
	endfunction

	// fill the open child slot of the stack top, true when the tree closes
	function automatic bit hang_child(logic [NODE_W-1:0] v);
		hufd_stk_t  top;
		logic [7:0] r;
		if (depth == 0) begin
			root = v;
			return 1'b0;
		end
		top = stk[8'(depth - 1)];
		r = row_of(top.node);
		if (!top.right) begin
			lchild[r] = v;
			stk[8'(depth - 1)] = '{right: 1'b1, node: top.node};
			return 1'b0;
		end
		rchild[r] = v;
		depth = depth - DEPTH_W'(1);
		return depth == 0;
	endfunction

	function automatic void tree_complete();
		walk = root;
		done_cnt = '0;
		phase = (frame_len == 0) ? PH_DONE : PH_DECODE;
	endfunction

	function automatic void decode_byte(hufd_in_t item);
		logic              bt;
		logic [NODE_W-1:0] child;
		logic [FREE_W-1:0] node;
		logic [7:0]        r;
		bit                fin;
		for (int b = 7; b >= 0; b--) begin
			bt = item.in_byte[b];
			case (phase)
				PH_TREE: begin
					if (bits_left != 0) begin
						shreg = {shreg[6:0], bt};
						bits_left = bits_left - 4'd1;
						if (bits_left == 0) begin
							if (depth == 0) begin
								// whole header is one leaf
								root = {1'b0, shreg};
								add_due(8'd0, 1'b1, ERR_ONE_LEAF);
								phase = PH_DONE;
							end else if (hang_child({1'b0, shreg})) begin
								tree_complete();
							end
						end
					end else if (bt) begin
						node = free_node;
						if (node >= FREE_W'(NODE_LIMIT)) begin
							add_due(8'd0, 1'b1, ERR_TREE_SIZE);
							phase = PH_DONE;
						end else begin
							free_node = node + FREE_W'(1);
							void'(hang_child(node[NODE_W-1:0]));
							if (depth < DEPTH_W'(STACK_DEPTH)) begin
								stk[depth[7:0]] = '{right: 1'b0, node: node[NODE_W-1:0]};
								depth = depth + DEPTH_W'(1);
							end
						end
					end else begin
						bits_left = 4'd8;
						shreg = '0;
					end
				end
				PH_DECODE: begin
					r = row_of(walk);
					child = bt ? rchild[r] : lchild[r];
					if (child < NODE_W'(ALPHABET_SIZE)) begin
						done_cnt = done_cnt + COUNT_W'(1);
						fin = done_cnt >= frame_len;
						add_due(child[7:0], fin, ERR_NONE);
						walk = root;
						if (fin)
							phase = PH_DONE;
					end else begin
						walk = child;
					end
				end
				default: ;
			endcase
		end
		if (item.last_byte) begin
			if (phase != PH_DONE)
				add_due(8'd0, 1'b1, ERR_EARLY_END);
			new_frame();
		end
	endfunction

	task automatic flag_miss(input string field, input logic [7:0] got, input logic [7:0] exp_v);
		$display("mismatch at %0t on %s: got %0h want %0h", $time, field, got, exp_v);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len = '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				lchild[i] = '0;
				rchild[i] = '0;
			end
			for (int i = 0; i < STACK_DEPTH; i++)
				stk[i] = '0;
			new_frame();
			due_symbols.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				frame_len = cfg_wdata;
			if (out_valid && out_ready) begin
				if (due_symbols.size() == 0) begin
					flag_miss("unexpected item", out_data.symbol, 8'd0);
				end else begin
					want = due_symbols.pop_front();
					if (out_data.symbol !== want.symbol)
						flag_miss("symbol", out_data.symbol, want.symbol);
					if (out_data.last_result !== want.last_result)
						flag_miss("last_result", 8'(out_data.last_result), 8'(want.last_result));
					if (out_data.error_code !== want.error_code)
						flag_miss("error_code", 8'(out_data.error_code), 8'(want.error_code));
				end
			end
			if (in_valid && in_ready)
				decode_byte(in_data);
			pending = due_symbols.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hufd_pkg::*;

	localparam int RAND_ITEMS  = 60;
	localparam int SETTLE      = 24;
	localparam int HOLD_LEN    = 300;
	localparam int QUIET_LIMIT = 3000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	hufd_in_t           in_data   = '0;
	logic               out_ready = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               in_ready;
	logic               out_valid;
	hufd_out_t          out_data;
	int                 fails;
	int                 pending;

	bit idle_on   = 1'b1;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet     = 0;
	int sent      = 0;

	logic [COUNT_W-1:0] cur_len = '0;
	bit                 frame_bits[$];

	always #5 clk = ~clk;

	huffman_decoder_embedded_tree u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	hufd_checker u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.fails    (fails),
		.pending  (pending)
	);

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (!idle_on) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("huffman_decoder_embedded_tree verification failed");
			$finish;
		end
	end

	task automatic put_bits(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			frame_bits.push_back(v[i]);
	endtask

	task automatic pad_to_byte();
		while (frame_bits.size() % 8 != 0)
			frame_bits.push_back(1'($urandom_range(1)));
	endtask

	// pre-order header with n_int internal nodes and random leaf symbols
	task automatic put_tree(input int n_int);
		int need;
		int rem;
		need = 1;
		rem = n_int;
		while (need > 0) begin
			if (rem > 0 && (need == 1 || $urandom_range(1) == 1)) begin
				put_bits(32'd1, 1);
				rem--;
				need++;
			end else begin
				put_bits(32'd0, 1);
				put_bits($urandom_range(255), 8);
				need--;
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (idle_on)
			while ($urandom_range(99) < 26) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, last_byte: lst};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// pad, append random code bytes and send, last_byte on the final item
	task automatic send_frame(input int data_bytes);
		int         nb;
		logic [7:0] b;
		pad_to_byte();
		repeat (data_bytes)
			put_bits($urandom_range(255), 8);
		if (frame_bits.size() == 0)
			put_bits($urandom_range(255), 8);
		nb = frame_bits.size() / 8;
		for (int i = 0; i < nb; i++) begin
			for (int k = 0; k < 8; k++)
				b[7-k] = frame_bits[i*8+k];
			send_byte(b, i == nb - 1);
		end
		frame_bits.delete();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic write_len(input logic [COUNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_len = v;
	endtask

	initial begin
		int base;
		int kind;
		int r;
		int n_int;
		int cap;
		int k;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// length zero after reset: a two-leaf tree gives nothing
		put_bits({13'd0, 1'b1, 1'b0, 8'h00, 1'b0, 8'hFF}, 19);
		send_frame(0);
		// lone leaf is flagged even at length zero
		put_bits({23'd0, 1'b0, 8'hA5}, 9);
		send_frame(0);
		// stream stops inside a leaf symbol
		put_bits(32'h80, 8);
		send_frame(0);

		write_len(24'd1);
		put_bits({13'd0, 1'b1, 1'b0, 8'h3C, 1'b0, 8'hC3}, 19);
		pad_to_byte();
		put_bits(32'hFF, 8);
		send_frame(1);
		put_bits({23'd0, 1'b0, 8'h00}, 9);
		send_frame(0);
		put_bits(32'h00, 8);
		send_frame(0);

		// largest length: eight symbols per byte, then the frame runs dry
		write_len(24'hFFFFFF);
		put_bits({13'd0, 1'b1, 1'b0, 8'h5A, 1'b0, 8'hA5}, 19);
		pad_to_byte();
		put_bits(32'h00, 8);
		put_bits(32'hFF, 8);
		send_frame(0);

		write_len(24'd3);
		put_tree(3);
		send_frame(2);

		// too many internal nodes
		repeat (33)
			put_bits(32'hFF, 8);
		send_frame(0);

		// receiver holds off while a long frame backs up into the input
		write_len(24'd30);
		hold_reqs++;
		put_bits({13'd0, 1'b1, 1'b0, 8'h81, 1'b0, 8'h7E}, 19);
		send_frame(4);

		base = sent;
		while (sent < base + RAND_ITEMS) begin
			idle_on = !((sent - base) >= 20 && (sent - base) < 45);
			if ($urandom_range(2) == 0) begin
				r = $urandom_range(99);
				if (r < 10)
					write_len(24'd0);
				else if (r < 18)
					write_len(24'hFFFFFF);
				else if (r < 28)
					write_len(COUNT_W'($urandom));
				else
					write_len(COUNT_W'($urandom_range(1, 12)));
			end
			r = $urandom_range(99);
			if (r < 80)
				n_int = $urandom_range(1, 4);
			else if (r < 95)
				n_int = $urandom_range(5, 9);
			else
				n_int = $urandom_range(10, 16);
			cap = (cur_len > 10) ? 10 : int'(cur_len);
			kind = $urandom_range(99);
			if (kind < 65) begin
				put_tree(n_int);
				send_frame((cap * n_int + 7) / 8 + $urandom_range(1));
			end else if (kind < 78) begin
				put_tree(n_int);
				if ($urandom_range(1) == 1) begin
					k = $urandom_range(1, frame_bits.size() - 1);
					while (frame_bits.size() > k)
						void'(frame_bits.pop_back());
				end
				send_frame(0);
			end else if (kind < 88) begin
				put_bits({23'd0, 1'b0, 8'($urandom_range(255))}, 9);
				send_frame($urandom_range(1));
			end else begin
				repeat ($urandom_range(1, 4))
					put_bits($urandom_range(255), 8);
				send_frame(0);
			end
		end
		idle_on = 1'b1;

		drain();
		if (fails == 0 && pending == 0)
			$display("huffman_decoder_embedded_tree verification clean");
		else
			$display("huffman_decoder_embedded_tree verification failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/hufd_pkg.sv
hw/rtl/hufd_tables.sv
hw/rtl/huffman_decoder_embedded_tree.sv
verif/hufd_checker.sv
verif/tb_top.sv
